FILE: hdl/i2cmrr_pkg.sv
// Shared types and constants for the I2C master register-read block.
// No dependencies; imported by every module under hdl/.
`default_nettype none

package i2cmrr_pkg;

   localparam int TickWidth   = 10;
   localparam int CsrIdxWidth = 2;
   localparam int ReqWidth    = 24;
   localparam int RspWidth    = 24;

   // register indexes on the configuration port
   localparam logic [CsrIdxWidth-1:0] CSR_START_HOLD = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_LOW        = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_HIGH       = 2'd2;

   localparam logic [TickWidth-1:0] START_HOLD_RST = 10'd4;
   localparam logic [TickWidth-1:0] LOW_RST        = 10'd5;
   localparam logic [TickWidth-1:0] HIGH_RST       = 10'd4;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;

   // sequencer phases, one-hot
   typedef enum logic [11:0] {
      PH_IDLE      = 12'b0000_0000_0001,
      PH_S1_SETUP  = 12'b0000_0000_0010,
      PH_S1_HOLD   = 12'b0000_0000_0100,
      PH_S2_SETUP  = 12'b0000_0000_1000,
      PH_S2_HOLD   = 12'b0000_0001_0000,
      PH_BIT_LOW   = 12'b0000_0010_0000,
      PH_BIT_RISE  = 12'b0000_0100_0000,
      PH_BIT_HIGH  = 12'b0000_1000_0000,
      PH_STOP_LOW  = 12'b0001_0000_0000,
      PH_STOP_RISE = 12'b0010_0000_0000,
      PH_STOP_HOLD = 12'b0100_0000_0000,
      PH_STOP_TAIL = 12'b1000_0000_0000
   } phase_type;

   // which byte of the transaction is on the bus, one-hot
   typedef enum logic [4:0] {
      ST_ADDR_W = 5'b00001,
      ST_REG    = 5'b00010,
      ST_ADDR_R = 5'b00100,
      ST_DATA1  = 5'b01000,
      ST_DATA2  = 5'b10000
   } stage_type;

   typedef struct packed {
      logic [TickWidth-1:0] start_hold_ticks;
      logic [TickWidth-1:0] low_ticks;
      logic [TickWidth-1:0] high_ticks;
   } cfg_type;

   typedef struct packed {
      logic       clear_error;
      logic       sda_in;
      logic       scl_in;
      logic [7:0] register_address;
      logic [6:0] device_address;
      logic       word_read;
      logic       go;
   } req_type;

   typedef struct packed {
      logic        no_ack_error;
      logic [15:0] read_value;
      logic        done_res;
      logic        busy_res;
      logic        sda_pull_low;
      logic        scl_pull_low;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/i2cmrr_csr.sv
// Timing registers written through the configuration channel.
// Depends on i2cmrr_pkg.
`default_nettype none

module i2cmrr_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [i2cmrr_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [i2cmrr_pkg::TickWidth-1:0]    csr_data,
   output i2cmrr_pkg::cfg_type                      cfg
);
   import i2cmrr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // writes always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_START_HOLD: cfg_in.start_hold_ticks = csr_data;
            CSR_LOW:        cfg_in.low_ticks        = csr_data;
            CSR_HIGH:       cfg_in.high_ticks       = csr_data;
            default:        cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_hold_ticks <= START_HOLD_RST;
         cfg_ff.low_ticks        <= LOW_RST;
         cfg_ff.high_ticks       <= HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hdl/i2cmrr_seq.sv
// Bus sequencer: state registers and the per-tick next-state logic.
// Depends on i2cmrr_pkg.
`default_nettype none

module i2cmrr_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire i2cmrr_pkg::req_type  item,
   input  wire i2cmrr_pkg::cfg_type  cfg,
   output i2cmrr_pkg::rsp_type       result
);
   import i2cmrr_pkg::*;

   phase_type             phase_ff, phase_in;
   stage_type             stage_ff, stage_in;
   logic [TickWidth-1:0]  tick_ff, tick_in;
   logic [7:0]            shift_ff, shift_in;
   logic [3:0]            bit_ff, bit_in;
   logic [15:0]           word_ff, word_in;
   logic                  nack_ff, nack_in;
   logic [6:0]            dev_ff, dev_in;
   logic [7:0]            reg_ff, reg_in;
   logic                  wide_ff, wide_in;
   logic                  scl_ff, scl_in_r;
   logic                  sda_ff, sda_in_r;

   logic [TickWidth-1:0]  limit;
   logic                  hit;
   logic [TickWidth-1:0]  tick_next;
   logic [7:0]            shift_new;
   logic                  reading;
   logic                  done;

   // counter limit for the current phase
   always_comb begin
      limit = cfg.low_ticks;
      if (phase_ff == PH_S1_SETUP || phase_ff == PH_S2_SETUP) begin
         limit = cfg.start_hold_ticks;
      end else if (phase_ff == PH_S1_HOLD || phase_ff == PH_S2_HOLD ||
                   phase_ff == PH_BIT_HIGH || phase_ff == PH_STOP_HOLD) begin
         limit = cfg.high_ticks;
      end
   end

   // a limit of zero ends on the first tick, as a limit of one
   assign hit       = ({1'b0, tick_ff} + 11'd1) >= {1'b0, limit};
   assign tick_next = hit ? '0 : tick_ff + 10'd1;
   assign shift_new = {shift_ff[6:0], item.sda_in};
   assign reading   = (stage_ff == ST_DATA1) || (stage_ff == ST_DATA2);

   // next state for one tick
   always_comb begin
      phase_in = phase_ff;
      stage_in = stage_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      bit_in   = bit_ff;
      word_in  = word_ff;
      dev_in   = dev_ff;
      reg_in   = reg_ff;
      wide_in  = wide_ff;
      scl_in_r = scl_ff;
      sda_in_r = sda_ff;
      done     = 1'b0;
      nack_in  = item.clear_error ? 1'b0 : nack_ff;

      unique case (phase_ff)
         PH_IDLE: begin
            scl_in_r = 1'b0;
            sda_in_r = 1'b0;
            if (item.go) begin
               dev_in   = item.device_address;
               reg_in   = item.register_address;
               wide_in  = item.word_read;
               tick_in  = '0;
               phase_in = PH_S1_SETUP;
            end
         end
         PH_S1_SETUP, PH_S2_SETUP: begin
            scl_in_r = 1'b0;
            sda_in_r = 1'b0;
            if (!item.scl_in) begin
               tick_in = '0;
            end else begin
               tick_in = tick_next;
               if (hit) begin
                  sda_in_r = 1'b1;
                  phase_in = (phase_ff == PH_S1_SETUP) ? PH_S1_HOLD : PH_S2_HOLD;
               end
            end
         end
         PH_S1_HOLD, PH_S2_HOLD: begin
            tick_in = tick_next;
            if (hit) begin
               scl_in_r = 1'b1;
               bit_in   = '0;
               tick_in  = '0;
               phase_in = PH_BIT_LOW;
               if (phase_ff == PH_S1_HOLD) begin
                  shift_in = {dev_ff, 1'b0};
                  stage_in = ST_ADDR_W;
               end else begin
                  shift_in = {dev_ff, 1'b1};
                  stage_in = ST_ADDR_R;
               end
            end
         end
         PH_BIT_LOW: begin
            // data bit, or the acknowledge slot after eight bits
            if (!bit_ff[3]) begin
               sda_in_r = ~shift_ff[7];
            end else begin
               sda_in_r = (stage_ff == ST_DATA1) && wide_ff;
            end
            tick_in = tick_next;
            if (hit) begin
               scl_in_r = 1'b0;
               phase_in = PH_BIT_RISE;
            end
         end
         PH_BIT_RISE: begin
            // wait out clock stretching
            if (item.scl_in) begin
               tick_in  = '0;
               phase_in = PH_BIT_HIGH;
            end
         end
         PH_BIT_HIGH: begin
            tick_in = tick_next;
            if (hit) begin
               scl_in_r = 1'b1;
               phase_in = PH_BIT_LOW;
               if (!bit_ff[3]) begin
                  shift_in = shift_new;
                  bit_in   = bit_ff + 4'd1;
                  if (bit_ff == 4'd7 && reading) begin
                     if (stage_ff == ST_DATA1) begin
                        word_in = wide_ff ? {shift_new, BYTE_ZEROS}
                                          : {BYTE_ZEROS, shift_new};
                     end else begin
                        word_in = {word_ff[15:8], shift_new};
                     end
                  end
               end else begin
                  if (!reading && item.sda_in) begin
                     nack_in = 1'b1;
                  end
                  bit_in  = '0;
                  tick_in = '0;
                  if (stage_ff == ST_ADDR_W) begin
                     shift_in = reg_ff;
                     stage_in = ST_REG;
                  end else if (stage_ff == ST_REG) begin
                     bit_in   = bit_ff;
                     phase_in = PH_S2_SETUP;
                  end else if (stage_ff == ST_ADDR_R) begin
                     shift_in = BYTE_ONES;
                     stage_in = ST_DATA1;
                  end else if (stage_ff == ST_DATA1 && wide_ff) begin
                     shift_in = BYTE_ONES;
                     stage_in = ST_DATA2;
                  end else begin
                     bit_in   = bit_ff;
                     shift_in = BYTE_ONES;
                     phase_in = PH_STOP_LOW;
                  end
               end
            end
         end
         PH_STOP_LOW: begin
            sda_in_r = 1'b1;
            tick_in  = tick_next;
            if (hit) begin
               scl_in_r = 1'b0;
               phase_in = PH_STOP_RISE;
            end
         end
         PH_STOP_RISE: begin
            if (item.scl_in) begin
               tick_in  = '0;
               phase_in = PH_STOP_HOLD;
            end
         end
         PH_STOP_HOLD: begin
            tick_in = tick_next;
            if (hit) begin
               sda_in_r = 1'b0;
               phase_in = PH_STOP_TAIL;
            end
         end
         PH_STOP_TAIL: begin
            tick_in = tick_next;
            if (hit) begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
            scl_in_r = 1'b0;
            sda_in_r = 1'b0;
         end
      endcase
   end

   // state update on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         stage_ff <= ST_ADDR_W;
         tick_ff  <= '0;
         shift_ff <= BYTE_ONES;
         bit_ff   <= '0;
         word_ff  <= '0;
         nack_ff  <= 1'b0;
         dev_ff   <= '0;
         reg_ff   <= '0;
         wide_ff  <= 1'b0;
         scl_ff   <= 1'b0;
         sda_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         stage_ff <= stage_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
         bit_ff   <= bit_in;
         word_ff  <= word_in;
         nack_ff  <= nack_in;
         dev_ff   <= dev_in;
         reg_ff   <= reg_in;
         wide_ff  <= wide_in;
         scl_ff   <= scl_in_r;
         sda_ff   <= sda_in_r;
      end
   end

   // result word shows the state after this tick
   always_comb begin
      result.scl_pull_low = scl_in_r;
      result.sda_pull_low = sda_in_r;
      result.busy_res     = (phase_in != PH_IDLE);
      result.done_res     = done;
      result.read_value   = word_in;
      result.no_ack_error = nack_in;
   end

endmodule

`default_nettype wire

FILE: hdl/i2c_master_register_read.sv
// Top level of the I2C master register-read block: stream ports, output register.
// Depends on i2cmrr_pkg, i2cmrr_csr and i2cmrr_seq.
//
//   channel  | direction | word
//   req_     | in        | one bus timing tick with request and sampled lines
//   rsp_     | out       | line drives and status after that tick
//   csr_     | in        | write of one timing register
//
// One word in, one word out; a new request word is taken every cycle while the
// response register is empty or being drained; the response is registered.
// The sequencer state advances only on accepted request words.
// Reset is synchronous: bus released, idle, timing registers at 4/5/4.
// A stalled response holds its word and stops intake until it is taken.
`default_nettype none

module i2c_master_register_read (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // from bit 0: go, word_read, device_address[6:0], register_address[7:0],
   // scl_in, sda_in, clear_error, zero pad
   input  wire logic [i2cmrr_pkg::ReqWidth-1:0]     req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // from bit 0: scl_pull_low, sda_pull_low, busy_res, done_res,
   // read_value[15:0], no_ack_error, zero pad
   output logic [i2cmrr_pkg::RspWidth-1:0]          rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [i2cmrr_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [i2cmrr_pkg::TickWidth-1:0]    csr_data
);
   import i2cmrr_pkg::*;

   cfg_type  cfg;
   req_type  item;
   rsp_type  result;
   logic     step;

   rsp_type  rsp_ff, rsp_in;
   logic     rsp_valid_ff, rsp_valid_in;

   assign item = req_type'(req_tdata[$bits(req_type)-1:0]);

   i2cmrr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2cmrr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   // intake whenever the response register is free this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspWidth-$bits(rsp_type)){1'b0}}, rsp_ff};

endmodule

`default_nettype wire
